// File: rtl/core/cfl_pkg.sv
// Shared types, constants and helpers for the CFL time-step reducer.
package cfl_pkg;

  localparam int DATA_W = 32;
  localparam int VAL_W  = 48;
  localparam int SUM_W  = 50;
  localparam int STEP_W = 32;
  localparam int CFG_W  = 32;

  localparam logic [VAL_W-1:0]  VMAX     = {VAL_W{1'b1}};
  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
  localparam logic [18:0]       ONE_Q16  = 19'd65536;
  // 2^24 shifted up by 16 inside the divider gives 2^40
  localparam logic [63:0]       RECIP_NUM = 64'd16777216;

  typedef struct packed {
    logic signed [DATA_W-1:0] density;
    logic signed [DATA_W-1:0] momentum_x;
    logic signed [DATA_W-1:0] momentum_y;
    logic signed [DATA_W-1:0] momentum_z;
    logic signed [DATA_W-1:0] field_x;
    logic signed [DATA_W-1:0] field_y;
    logic signed [DATA_W-1:0] field_z;
    logic signed [DATA_W-1:0] total_energy;
    logic                     last_cell;
  } in_item_t;

  typedef struct packed {
    logic [STEP_W-1:0] time_step;
    logic              bad_cell_seen;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     rho_pos;
  } q_item_t;

  typedef struct packed {
    logic [18:0] gamma_ratio;
    logic [31:0] inv_spacing_x;
    logic [31:0] inv_spacing_y;
    logic [16:0] courant_factor;
    logic [31:0] start_step;
    logic [15:0] speed_guard;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_GAMMA   = 3'd0,
    CFG_INV_X   = 3'd1,
    CFG_INV_Y   = 3'd2,
    CFG_COURANT = 3'd3,
    CFG_START   = 3'd4,
    CFG_GUARD   = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_DIV  = 3'b010,
    OP_SQRT = 3'b100
  } op_e;

  typedef enum logic [4:0] {
    ST_U  = 5'd0,
    ST_V  = 5'd1,
    ST_W  = 5'd2,
    ST_UU = 5'd3,
    ST_VV = 5'd4,
    ST_WW = 5'd5,
    ST_BX = 5'd6,
    ST_BY = 5'd7,
    ST_BZ = 5'd8,
    ST_RV = 5'd9,
    ST_P  = 5'd10,
    ST_G  = 5'd11,
    ST_CS = 5'd12,
    ST_CA = 5'd13,
    ST_SQ = 5'd14,
    ST_DX = 5'd15,
    ST_DY = 5'd16,
    ST_DT = 5'd17
  } step_e;

  function automatic logic [VAL_W-1:0] sat48(input logic [SUM_W-1:0] x);
    logic [VAL_W-1:0] r;
    r = (x > {{(SUM_W-VAL_W){1'b0}}, VMAX}) ? VMAX : x[VAL_W-1:0];
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] mag(input logic signed [DATA_W-1:0] x);
    logic [DATA_W-1:0] m;
    m = x[DATA_W-1] ? (~x + 1'b1) : x;
    return {{(VAL_W-DATA_W){1'b0}}, m};
  endfunction

endpackage

// File: rtl/core/mhd_cfl_time_step.sv
// Top level of the ideal-MHD CFL time-step reducer: configuration registers and wiring.
// With the back end free, a closing cell with positive density is popped, runs eighteen issue/wait
//   steps on the bit-serial unit (eleven multiplies, six divides, one root) and the end state
//   before its result beat is valid; a cell with nonpositive density goes straight to the end state.
// The back end works on one cell at a time; the two-beat queue takes input meanwhile.
//   Reset: default registers, no sweep open.
module mhd_cfl_time_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cfl_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cfl_pkg::out_item_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  import cfl_pkg::*;

  cfg_t    cfg_q;
  logic    q_valid, q_pop;
  q_item_t q_item;

  // Register writes land the cycle after; out-of-range indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gamma_ratio    <= 19'd109227;
      cfg_q.inv_spacing_x  <= 32'd65536;
      cfg_q.inv_spacing_y  <= 32'd65536;
      cfg_q.courant_factor <= 17'd26214;
      cfg_q.start_step     <= 32'hFFFF_FFFF;
      cfg_q.speed_guard    <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAMMA:   cfg_q.gamma_ratio    <= cfg_data_i[18:0];
        CFG_INV_X:   cfg_q.inv_spacing_x  <= cfg_data_i;
        CFG_INV_Y:   cfg_q.inv_spacing_y  <= cfg_data_i;
        CFG_COURANT: cfg_q.courant_factor <= cfg_data_i[16:0];
        CFG_START:   cfg_q.start_step     <= cfg_data_i;
        CFG_GUARD:   cfg_q.speed_guard    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Front: accept and tag cells with nonpositive density.
  cfl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // Back: speeds, pressure, fast bound, cell step and running minimum.
  cfl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: rtl/core/cfl_front.sv
// Front end: accepts cells, tags nonpositive density, two-entry queue to the back end.
module cfl_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cfl_pkg::in_item_t in_data_i,
  output logic             q_valid_o,
  output cfl_pkg::q_item_t q_item_o,
  input  logic             q_pop_i
);
  import cfl_pkg::*;

  q_item_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].item    <= in_data_i;
      mem_q[wr_ptr_q].rho_pos <= !in_data_i.density[DATA_W-1] && (in_data_i.density != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/core/cfl_arith.sv
// Shared serial unit: saturating Q32.16 multiply, divide and integer square root.
module cfl_arith (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  cfl_pkg::op_e op_i,
  input  logic [63:0]  a_i,
  input  logic [47:0]  b_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [47:0]  res_o
);
  import cfl_pkg::*;

  op_e         op_q;
  logic [6:0]  cnt_q;
  logic        done_q;
  logic [95:0] acc_q, sh_q;
  logic [63:0] mp_q, bit_q;
  logic [47:0] d_q, rem_q;
  logic [48:0] rem_t;
  logic [63:0] trial;

  assign busy_o = (cnt_q != 7'd0);
  assign done_o = done_q;
  assign rem_t  = {rem_q, mp_q[63]};
  assign trial  = sh_q[63:0] + bit_q;

  always_comb begin
    case (op_q)
      OP_MUL:  res_o = (acc_q[95:64] != '0) ? VMAX : acc_q[63:16];
      OP_DIV:  res_o = (acc_q[63:48] != '0) ? VMAX : acc_q[47:0];
      OP_SQRT: res_o = sh_q[47:0];
      default: res_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 7'd0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= busy_o && (cnt_q == 7'd1);
      if (start_i) begin
        op_q <= op_i;
        case (op_i)
          OP_MUL:  cnt_q <= 7'd48;
          OP_DIV:  cnt_q <= 7'd64;
          OP_SQRT: cnt_q <= 7'd32;
          default: cnt_q <= 7'd0;
        endcase
      end else if (busy_o) begin
        cnt_q <= cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      case (op_i)
        OP_MUL: begin
          acc_q <= '0;
          sh_q  <= {48'd0, a_i[47:0]};
          mp_q  <= {16'd0, b_i};
        end
        OP_DIV: begin
          acc_q <= '0;
          mp_q  <= {a_i[47:0], 16'd0};
          d_q   <= b_i;
          rem_q <= '0;
        end
        default: begin
          mp_q  <= a_i;
          sh_q  <= '0;
          bit_q <= 64'h4000_0000_0000_0000;
        end
      endcase
    end else if (busy_o) begin
      case (op_q)
        OP_MUL: begin
          if (mp_q[0]) acc_q <= acc_q + sh_q;
          sh_q <= {sh_q[94:0], 1'b0};
          mp_q <= {1'b0, mp_q[63:1]};
        end
        OP_DIV: begin
          mp_q <= {mp_q[62:0], 1'b0};
          if (rem_t >= {1'b0, d_q}) begin
            rem_q <= 48'(rem_t - {1'b0, d_q});
            acc_q <= {acc_q[94:0], 1'b1};
          end else begin
            rem_q <= rem_t[47:0];
            acc_q <= {acc_q[94:0], 1'b0};
          end
        end
        default: begin
          if (mp_q >= trial) begin
            mp_q <= mp_q - trial;
            sh_q <= {32'd0, ({1'b0, sh_q[63:1]} + bit_q)};
          end else begin
            sh_q <= {32'd0, 1'b0, sh_q[63:1]};
          end
          bit_q <= {2'b00, bit_q[63:2]};
        end
      endcase
    end
  end

endmodule

// File: rtl/core/cfl_back.sv
// Back end: per-cell sequencer over the shared unit, running minimum and result register.
module cfl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfl_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  cfl_pkg::q_item_t   q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cfl_pkg::out_item_t out_data_o
);
  import cfl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_END   = 4'b1000
  } state_e;

  state_e       state_q;
  step_e        step_q;
  in_item_t     item_q;
  logic [47:0]  u_q, v_q, tmp_q, b2_q, r48;
  logic [49:0]  sum_q;
  logic [31:0]  min_q;
  logic         open_q, bad_q, out_valid_q;
  out_item_t    out_q;

  logic         start, busy, done;
  op_e          op;
  logic [63:0]  opa;
  logic [47:0]  opb, res;
  logic [18:0]  gm1;
  logic signed [SUM_W-1:0] pint;
  logic [31:0]  cand;
  logic [48:0]  dt_full;
  logic [32:0]  dt_sh;
  logic         out_load;

  assign r48   = {{(VAL_W-DATA_W){1'b0}}, item_q.density};
  assign gm1   = (cfg_i.gamma_ratio >= ONE_Q16) ? (cfg_i.gamma_ratio - ONE_Q16) : '0;
  assign start = (state_q == S_ISSUE);
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  cfl_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (op),
    .a_i    (opa),
    .b_i    (opb),
    .busy_o (busy),
    .done_o (done),
    .res_o  (res)
  );

  always_comb begin
    op  = OP_MUL;
    opa = '0;
    opb = '0;
    case (step_q)
      ST_U:  begin op = OP_DIV; opa = {16'd0, mag(item_q.momentum_x)}; opb = r48; end
      ST_V:  begin op = OP_DIV; opa = {16'd0, mag(item_q.momentum_y)}; opb = r48; end
      ST_W:  begin op = OP_DIV; opa = {16'd0, mag(item_q.momentum_z)}; opb = r48; end
      ST_UU: begin opa = {16'd0, u_q}; opb = u_q; end
      ST_VV: begin opa = {16'd0, v_q}; opb = v_q; end
      ST_WW: begin opa = {16'd0, tmp_q}; opb = tmp_q; end
      ST_BX: begin opa = {16'd0, mag(item_q.field_x)}; opb = mag(item_q.field_x); end
      ST_BY: begin opa = {16'd0, mag(item_q.field_y)}; opb = mag(item_q.field_y); end
      ST_BZ: begin opa = {16'd0, mag(item_q.field_z)}; opb = mag(item_q.field_z); end
      ST_RV: begin opa = {16'd0, r48}; opb = tmp_q; end
      ST_P:  begin opa = {45'd0, gm1}; opb = tmp_q; end
      ST_G:  begin opa = {45'd0, cfg_i.gamma_ratio}; opb = tmp_q; end
      ST_CS: begin op = OP_DIV; opa = {16'd0, tmp_q}; opb = r48; end
      ST_CA: begin op = OP_DIV; opa = {16'd0, b2_q}; opb = r48; end
      ST_SQ: begin op = OP_SQRT; opa = {tmp_q, 16'd0}; end
      ST_DX: begin opa = {16'd0, u_q}; opb = {16'd0, cfg_i.inv_spacing_x}; end
      ST_DY: begin opa = {16'd0, v_q}; opb = {16'd0, cfg_i.inv_spacing_y}; end
      ST_DT: begin op = OP_DIV; opa = RECIP_NUM; opb = tmp_q; end
      default: begin op = OP_MUL; end
    endcase
  end

  // internal energy: e - rho|v|^2/2 - |B|^2/2
  assign pint = $signed({{(SUM_W-DATA_W){item_q.total_energy[DATA_W-1]}}, item_q.total_energy})
              - $signed({3'b000, res[47:1]}) - $signed({3'b000, b2_q[47:1]});
  assign cand = (res[47:32] != '0) ? STEP_MAX : res[31:0];

  assign dt_full  = min_q * cfg_i.courant_factor;
  assign dt_sh    = dt_full[48:16];
  assign out_load = (state_q == S_END) && item_q.last_cell && (!out_valid_q || out_ready_i);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= ST_U;
      open_q      <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      min_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            if (!open_q) begin
              min_q  <= cfg_i.start_step;
              open_q <= 1'b1;
            end
            step_q <= ST_U;
            if (q_item_i.rho_pos) begin
              state_q <= S_ISSUE;
            end else begin
              bad_q   <= 1'b1;
              state_q <= S_END;
            end
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (done) begin
            if (step_q == ST_RV && pint[SUM_W-1]) bad_q <= 1'b1;
            if (step_q == ST_DT) begin
              if (cand < min_q) min_q <= cand;
              state_q <= S_END;
            end else begin
              step_q  <= step_e'(step_q + 5'd1);
              state_q <= S_ISSUE;
            end
          end
        end
        S_END: begin
          if (!item_q.last_cell) begin
            state_q <= S_IDLE;
          end else if (out_load) begin
            open_q      <= 1'b0;
            bad_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) item_q <= q_item_i.item;
    if (out_load) begin
      out_q.time_step     <= (dt_sh[32]) ? STEP_MAX : dt_sh[31:0];
      out_q.bad_cell_seen <= bad_q;
    end
    if (state_q == S_WAIT && done) begin
      case (step_q)
        ST_U:  u_q <= res;
        ST_V:  v_q <= res;
        ST_W:  tmp_q <= res;
        ST_UU: sum_q <= {2'b00, res};
        ST_VV: sum_q <= sum_q + {2'b00, res};
        ST_WW: tmp_q <= sat48(sum_q + {2'b00, res});
        ST_BX: sum_q <= {2'b00, res};
        ST_BY: sum_q <= sum_q + {2'b00, res};
        ST_BZ: b2_q <= sat48(sum_q + {2'b00, res});
        ST_RV: tmp_q <= pint[SUM_W-1] ? '0 : pint[47:0];
        ST_P:  tmp_q <= res;
        ST_G:  tmp_q <= res;
        ST_CS: tmp_q <= res;
        ST_CA: tmp_q <= sat48({2'b00, tmp_q} + {2'b00, res});
        ST_SQ: begin
          u_q <= sat48({2'b00, u_q} + {2'b00, res});
          v_q <= sat48({2'b00, v_q} + {2'b00, res});
        end
        ST_DX: sum_q <= {2'b00, res};
        ST_DY: tmp_q <= sat48(sum_q + {2'b00, res} + {34'd0, cfg_i.speed_guard});
        default: ;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !busy)
    else $error("shared unit started while busy");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (!open_q && !bad_q && out_valid_q))
    else $error("sweep close did not clear state");

  a_result_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_END))
    else $error("result raised outside end state");

endmodule

// File: test/tb_mhd_cfl_time_step.sv
// Self-checking testbench for the ideal-MHD CFL time-step reducer.
`timescale 1ns / 1ps

module tb_mhd_cfl_time_step;
  import cfl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  // Drain allowance: one back-end pass of a cell with positive density, plus margin.
  localparam int unsigned DRAIN_CYCLES = 1200;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  mhd_cfl_time_step i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the configuration and of the sweep state.
  // ---------------------------------------------------------------------------
  cfg_t        shadow_cfg;
  logic [31:0] sweep_min;
  logic        sweep_bad;
  logic        sweep_open;
  out_item_t   step_q[$];   // time steps still owed by the block

  int unsigned errors = 0;
  int unsigned cells_sent = 0;
  int unsigned steps_seen = 0;
  int unsigned bad_cells = 0;
  int unsigned cycles = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic logic [47:0] fx_mul(input logic [47:0] a, input logic [47:0] b);
    logic [95:0] p;
    p = ({48'd0, a} * {48'd0, b}) >> 16;
    return (p > 96'(VMAX)) ? VMAX : p[47:0];
  endfunction

  function automatic logic [47:0] fx_div(input logic [47:0] a, input logic [47:0] b);
    logic [63:0] q;
    if (b == '0) return VMAX;
    q = ({16'd0, a} << 16) / {16'd0, b};
    return (q > 64'(VMAX)) ? VMAX : q[47:0];
  endfunction

  function automatic logic [47:0] clip48(input logic [63:0] x);
    return (x > 64'(VMAX)) ? VMAX : x[47:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [47:0] abs_q(input logic signed [31:0] x);
    longint v;
    v = longint'(x);
    return (v < 0) ? 48'(-v) : 48'(v);
  endfunction

  // Folds one accepted cell into the sweep; queues the time step on the closing cell.
  task automatic fold_cell(input in_item_t c);
    logic [47:0] r, u, v, w, bx, by, bz, v2, b2, gm1, p, cs2, ca2, fast, spx, spy, den;
    logic [63:0] cand, dt;
    longint      pint;
    out_item_t   res;
    if (!sweep_open) begin
      sweep_min = shadow_cfg.start_step;
      sweep_open = 1'b1;
    end
    if (c.density <= 0) begin
      sweep_bad = 1'b1;
    end else begin
      r  = 48'(c.density);
      u  = fx_div(abs_q(c.momentum_x), r);
      v  = fx_div(abs_q(c.momentum_y), r);
      w  = fx_div(abs_q(c.momentum_z), r);
      bx = abs_q(c.field_x);
      by = abs_q(c.field_y);
      bz = abs_q(c.field_z);
      v2 = clip48(64'(fx_mul(u, u)) + fx_mul(v, v) + fx_mul(w, w));
      b2 = clip48(64'(fx_mul(bx, bx)) + fx_mul(by, by) + fx_mul(bz, bz));
      pint = longint'(c.total_energy) - longint'(fx_mul(r, v2) >> 1) - longint'(b2 >> 1);
      gm1 = (shadow_cfg.gamma_ratio >= 19'd65536) ? 48'(shadow_cfg.gamma_ratio - 19'd65536)
                                                  : 48'd0;
      if (pint < 0) begin
        sweep_bad = 1'b1;
        p = '0;
      end else begin
        p = fx_mul(gm1, 48'(pint));
      end
      cs2  = fx_div(fx_mul(48'(shadow_cfg.gamma_ratio), p), r);
      ca2  = fx_div(b2, r);
      fast = 48'(int_sqrt(64'(clip48(64'(cs2) + ca2)) << 16));
      spx  = clip48(64'(u) + fast);
      spy  = clip48(64'(v) + fast);
      den  = clip48(64'(fx_mul(spx, 48'(shadow_cfg.inv_spacing_x)))
                    + fx_mul(spy, 48'(shadow_cfg.inv_spacing_y))
                    + shadow_cfg.speed_guard);
      if (den == '0) cand = 64'(STEP_MAX);
      else begin
        cand = (64'd1 << 40) / {16'd0, den};
        if (cand > 64'(STEP_MAX)) cand = 64'(STEP_MAX);
      end
      if (cand < 64'(sweep_min)) sweep_min = cand[31:0];
    end
    if (c.last_cell) begin
      dt = (64'(sweep_min) * shadow_cfg.courant_factor) >> 16;
      res.time_step = (dt > 64'(STEP_MAX)) ? STEP_MAX : dt[31:0];
      res.bad_cell_seen = sweep_bad;
      if (sweep_bad) bad_cells++;
      step_q.push_back(res);
      sweep_min = shadow_cfg.start_step;
      sweep_bad = 1'b0;
      sweep_open = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one cell. Valid is only lowered when a gap really follows, so it is never
  // dropped and raised in one step.
  task automatic send_cell(input in_item_t c);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cells_sent++;
    fold_cell(c);
  endtask

  // Pauses the sender until every owed time step has come back, then lets any cell
  // still in the back end finish before registers are touched.
  task automatic drain_all();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (step_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One write, then the enable is held low before the task returns, so that back-to-back
  // writes never drive the enable twice in one step.
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GAMMA:   shadow_cfg.gamma_ratio    = val[18:0];
      CFG_INV_X:   shadow_cfg.inv_spacing_x  = val;
      CFG_INV_Y:   shadow_cfg.inv_spacing_y  = val;
      CFG_COURANT: shadow_cfg.courant_factor = val[16:0];
      CFG_START:   shadow_cfg.start_step     = val;
      CFG_GUARD:   shadow_cfg.speed_guard    = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] signed_upto(input int unsigned lim);
    logic signed [31:0] m;
    m = $urandom_range(lim);
    return $urandom_range(1) ? -m : m;
  endfunction

  // Mostly physical cells (positive density, energy large enough for positive
  // pressure most of the time); the rest raw noise over every bit.
  function automatic in_item_t rand_cell(input int unsigned last_pct);
    in_item_t c;
    if ($urandom_range(99) < 15) begin
      c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, 1'b0};
    end else begin
      c.density      = $urandom_range(32'h0100_0000, 32'h0000_1000);
      c.momentum_x   = signed_upto(32'h0010_0000);
      c.momentum_y   = signed_upto(32'h0010_0000);
      c.momentum_z   = signed_upto(32'h0004_0000);
      c.field_x      = signed_upto(32'h0004_0000);
      c.field_y      = signed_upto(32'h0004_0000);
      c.field_z      = signed_upto(32'h0004_0000);
      c.total_energy = $urandom_range(32'h4000_0000, 0) - 32'h0010_0000;
    end
    c.last_cell = ($urandom_range(99) < last_pct);
    return c;
  endfunction

  function automatic in_item_t mk_cell(input logic signed [31:0] rho, mx, my, mz,
                                       input logic signed [31:0] b, e, input logic last);
    in_item_t c;
    c = '{rho, mx, my, mz, b, -b, b, e, last};
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic run_random(input int unsigned n, input int unsigned idle_pct,
                            input int unsigned stall_pct);
    in_item_t c;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      c = rand_cell(12);
      if (i == n - 1) c.last_cell = 1'b1;
      send_cell(c);
    end
    drain_all();
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // one quiet cell, then extreme magnitudes in a single sweep
    send_cell(mk_cell(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 1'b1));
    send_cell(mk_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_cell(mk_cell(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    send_cell(mk_cell(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 1'b1));
    // nonpositive density only: sweep with no usable cell
    send_cell(mk_cell(0, 32'h1234_5678, 0, 0, 0, 0, 1'b0));
    send_cell(mk_cell(32'h8000_0000, 0, 0, 0, 0, 0, 1'b1));
    // negative pressure from negative energy, closing cell bad itself
    send_cell(mk_cell(32'h0002_0000, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 1'b0));
    send_cell(mk_cell(32'h0002_0000, 0, 0, 0, 0, 32'h8000_0000, 1'b1));
    // flag clears after it is reported
    send_cell(mk_cell(32'h0001_0000, 32'h0000_8000, 0, 0, 0, 32'h0010_0000, 1'b1));
    drain_all();
  endtask

  task automatic test_config_extremes();
    // zero denominator: no speed, no guard
    write_reg(CFG_GUARD, 32'd0);
    write_reg(CFG_COURANT, 32'd65536);
    send_cell(mk_cell(32'h0001_0000, 0, 0, 0, 0, 0, 1'b1));
    drain_all();
    // adiabatic index below one, then exactly one
    write_reg(CFG_GAMMA, 32'd40000);
    write_reg(CFG_GUARD, 32'd65535);
    send_cell(mk_cell(32'h0001_0000, 32'h0000_4000, 0, 0, 0, 32'h0100_0000, 1'b1));
    drain_all();
    write_reg(CFG_GAMMA, 32'd65536);
    write_reg(CFG_START, 32'd0);
    write_reg(CFG_COURANT, 32'd0);
    send_cell(mk_cell(32'h0001_0000, 32'h0000_4000, 0, 0, 0, 32'h0100_0000, 1'b1));
    drain_all();
    // extreme spacings, a larger adiabatic index and the largest start step
    write_reg(CFG_GAMMA, 32'd262144);
    write_reg(CFG_INV_X, 32'hFFFF_FFFF);
    write_reg(CFG_INV_Y, 32'd1);
    write_reg(CFG_COURANT, 32'd65536);
    write_reg(CFG_START, 32'hFFFF_FFFF);
    run_random(40, 0, 0);
    write_reg(CFG_INV_X, 32'd1);
    write_reg(CFG_INV_Y, 32'hFFFF_FFFF);
    write_reg(CFG_GAMMA, 32'd65537);
    write_reg(CFG_GUARD, 32'd0);
    run_random(40, 0, 0);
    // fine grid, small step start so the start value often wins
    write_reg(CFG_INV_X, 32'h0040_0000);
    write_reg(CFG_INV_Y, 32'h0008_0000);
    write_reg(CFG_START, 32'h0000_1000);
    write_reg(CFG_GUARD, 32'd1);
    write_reg(CFG_COURANT, 32'd26214);
    run_random(40, 0, 0);
    // back to the reset values
    write_reg(CFG_GAMMA, 32'd109227);
    write_reg(CFG_INV_X, 32'd65536);
    write_reg(CFG_INV_Y, 32'd65536);
    write_reg(CFG_START, 32'hFFFF_FFFF);
  endtask

  // Long receiver hold-off while cells keep coming, so the queue fills and in_ready_o
  // drops. Bad-density closing cells come back fast, so several results pile up.
  logic        hold_go = 1'b0;
  int unsigned hold_cnt = 0;

  task automatic test_backpressure();
    in_item_t c;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    for (int i = 0; i < 24; i++) begin
      c = rand_cell(0);
      if (i % 3 != 0) c.density = -$signed(32'($urandom_range(5)));
      c.last_cell = (i % 2 == 1);
      send_cell(c);
    end
    drain_all();
  endtask

  always @(posedge clk_i) begin
    if (hold_go) hold_cnt <= 3000;
    else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  // ---------------------------------------------------------------------------
  // Receiver and checker: values sampled at the edge are those from before it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      out_ready_i <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
      if (out_valid_o && out_ready_i) begin
        steps_seen++;
        if (step_q.size() == 0) begin
          report_mismatch("unexpected beat", out_data_o.time_step, 32'd0);
        end else begin
          want = step_q.pop_front();
          if (out_data_o.time_step !== want.time_step)
            report_mismatch("time_step", out_data_o.time_step, want.time_step);
          if (out_data_o.bad_cell_seen !== want.bad_cell_seen)
            report_mismatch("bad_cell_seen", 32'(out_data_o.bad_cell_seen),
                            32'(want.bad_cell_seen));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d time steps outstanding", cycles, step_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    shadow_cfg = '{19'd109227, 32'd65536, 32'd65536, 17'd26214, 32'hFFFF_FFFF, 16'd1};
    sweep_min  = shadow_cfg.start_step;
    sweep_bad  = 1'b0;
    sweep_open = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_extremes();
    test_backpressure();
    run_random(160, 0, 0);
    run_random(160, 79, 0);
    run_random(160, 0, 79);
    run_random(160, 34, 34);

    $display("Covered %0d cells and %0d time steps (%0d sweeps with bad cells)",
             cells_sent, steps_seen, bad_cells);
    $display("Phases: directed, register extremes, long hold-off, four idling mixes");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
